[hw/rtl/stcr_pkg.sv]
// Shared types and codes for the space-time cell reservation unit.
package stcr_pkg;

    localparam int CFG_W = 6;

    localparam logic [0:0] CFG_ROWS = 1'd0;
    localparam logic [0:0] CFG_COLS = 1'd1;

    localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;
    localparam logic [1:0] CMD_ADVANCE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CLIPPED  = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    // Number of ticks past now that a query looks ahead.
    localparam logic [1:0] QUERY_SPAN = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  robot_id;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [31:0] until_tick;
        logic [31:0] grace;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        holder_valid;
        logic [7:0]  holder_id;
        logic [31:0] now_tick;
    } out_item_t;

    typedef struct packed {
        logic        vld;
        logic [7:0]  robot;
        logic [31:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[hw/rtl/space_time_cell_reservation_unit.sv]
// Space-time cell reservation unit: top level with control sequencer and table memory.
// The unit keeps, for every grid cell, HORIZON tick slots telling which robot holds the
// cell at that tick; slot t mod HORIZON of a cell holds tick t, and each entry carries
// its absolute tick stamp so stale entries stop counting without any pruning. A reserve
// transaction is all or nothing: the window from now to until_tick (clipped to
// now+HORIZON-1, status 1) is read slot by slot, and only if no other robot holds any of
// it is the whole window written. Release clears this robot's entries more than grace
// ticks ahead, query reports the first holder from now to now+3, and advance moves the
// current tick on by one. Every command returns exactly one result transaction.
// Timing: all reservation state sits in one RAM of MAX_ROWS*MAX_COLS*HORIZON entries with
// one read and one write port and a registered read, so commands run one slot per cycle.
// Advance and invalid cells skip the scan; release walks every slot of the cell, query
// stops at the first holder, and reserve scans only its window and stops at a conflict.
// The next command is accepted in the cycle after the result is loaded into the output
// register, even while that result is still waiting.
// After reset the unit sweeps all MAX_ROWS*MAX_COLS*HORIZON entries (16384 by default)
// of the RAM to empty, one entry per cycle; s_ready stays low meanwhile, while
// configuration writes are taken as always.
module space_time_cell_reservation_unit
    import stcr_pkg::*;
#(
    parameter int HORIZON  = 16,
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration port
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    // command channel
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    // result channel
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS * HORIZON;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(HORIZON);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(HORIZON - 1);
    localparam logic [8:0]    ROWS_CAP  = 9'(MAX_ROWS);
    localparam logic [8:0]    COLS_CAP  = 9'(MAX_COLS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Slot of tick+1, given the slot of tick; 2^32 is not a multiple of HORIZON in
    // general, so the tick wrap restarts the slot at zero.
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] slot,
                                                input logic [31:0]   tick);
        logic [SW-1:0] r;
        if (tick == 32'hFFFF_FFFF || slot == LAST_SLOT) begin
            r = '0;
        end else begin
            r = slot + SW'(1);
        end
        return r;
    endfunction

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [31:0]      now_reg, now_next;
    logic [SW-1:0]    now_slot_reg, now_slot_next;
    logic [CFG_W-1:0] rows_reg, cols_reg;

    in_item_t         cmd_reg, cmd_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [SW-1:0]    last_reg, last_next;
    logic             issuing_reg, issuing_next;
    logic [SW-1:0]    cnt_reg, cnt_next;
    logic [31:0]      tick_k_reg, tick_k_next;
    logic [SW-1:0]    slot_k_reg, slot_k_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;
    logic [31:0]      pend_tick_reg, pend_tick_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;

    logic [1:0]       status_reg, status_next;
    logic             hv_reg, hv_next;
    logic [7:0]       hid_reg, hid_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    // memory port signals
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    entry_t           mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    entry_t           rd_ent;

    // decode helpers
    logic             cell_ok;
    logic [31:0]      base_full;
    logic [31:0]      span_full;
    logic             span_clip;
    logic             hold;
    logic [31:0]      rel_off;
    logic [AW-1:0]    slot_addr;

    assign rd_ent    = entry_t'(mem_rdata);
    assign slot_addr = base_reg + AW'(slot_k_reg);
    assign mem_raddr = slot_addr;

    always_comb begin
        cell_ok = ({4'b0, cmd_reg.row} < {3'b0, rows_reg}) && ({4'b0, cmd_reg.row} < ROWS_CAP)
               && ({4'b0, cmd_reg.col} < {3'b0, cols_reg}) && ({4'b0, cmd_reg.col} < COLS_CAP);
        base_full = (32'(cmd_reg.row) * 32'(MAX_COLS) + 32'(cmd_reg.col)) * 32'(HORIZON);
        span_full = (cmd_reg.until_tick > now_reg) ? (cmd_reg.until_tick - now_reg) : 32'd0;
        span_clip = (span_full >= 32'(HORIZON));
        hold      = rd_ent.vld && (rd_ent.stamp == pend_tick_reg);
        rel_off   = rd_ent.stamp - now_reg;
    end

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        now_next       = now_reg;
        now_slot_next  = now_slot_reg;
        cmd_next       = cmd_reg;
        base_next      = base_reg;
        last_next      = last_reg;
        issuing_next   = issuing_reg;
        cnt_next       = cnt_reg;
        tick_k_next    = tick_k_reg;
        slot_k_next    = slot_k_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        pend_tick_next = pend_tick_reg;
        pend_addr_next = pend_addr_reg;
        status_next    = status_reg;
        hv_next        = hv_reg;
        hid_next       = hid_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_addr;
        mem_wdata      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // sweep every entry to empty
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                status_next  = ST_OK;
                hv_next      = 1'b0;
                hid_next     = '0;
                base_next    = AW'(base_full);
                tick_k_next  = now_reg;
                slot_k_next  = now_slot_reg;
                cnt_next     = '0;
                issuing_next = 1'b1;
                if (cmd_reg.cmd == CMD_ADVANCE) begin
                    now_next      = now_reg + 32'd1;
                    now_slot_next = slot_inc(now_slot_reg, now_reg);
                    state_next    = S_DONE;
                end else if (!cell_ok) begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_SCAN;
                    case (cmd_reg.cmd)
                        CMD_RESERVE: begin
                            last_next   = span_clip ? LAST_SLOT : span_full[SW-1:0];
                            status_next = span_clip ? ST_CLIPPED : ST_OK;
                        end
                        CMD_RELEASE: last_next = LAST_SLOT;
                        default:     last_next = SW'(QUERY_SPAN);
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read per cycle
                if (issuing_reg) begin
                    pend_next      = 1'b1;
                    pend_last_next = (cnt_reg == last_reg);
                    pend_tick_next = tick_k_reg;
                    pend_addr_next = slot_addr;
                    tick_k_next    = tick_k_reg + 32'd1;
                    // release walks every slot of the cell once; the others follow the tick
                    slot_k_next    = slot_inc(slot_k_reg,
                                              (cmd_reg.cmd == CMD_RELEASE) ? 32'd0 : tick_k_reg);
                    cnt_next       = cnt_reg + SW'(1);
                    issuing_next   = (cnt_reg != last_reg);
                end
                // check the entry read in the previous cycle
                if (pend_reg) begin
                    case (cmd_reg.cmd)
                        CMD_RESERVE: begin
                            if (hold && rd_ent.robot != cmd_reg.robot_id) begin
                                status_next = ST_CONFLICT;
                                state_next  = S_DONE;
                            end else if (pend_last_reg) begin
                                tick_k_next = now_reg;
                                slot_k_next = now_slot_reg;
                                cnt_next    = '0;
                                state_next  = S_WRITE;
                            end
                        end
                        CMD_RELEASE: begin
                            if (rd_ent.vld && rd_ent.robot == cmd_reg.robot_id
                                && rel_off < 32'(HORIZON) && rel_off > cmd_reg.grace) begin
                                mem_we        = 1'b1;
                                mem_waddr     = pend_addr_reg;
                                mem_wdata     = rd_ent;
                                mem_wdata.vld = 1'b0;
                            end
                            if (pend_last_reg) begin
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                            if (hold) begin
                                hv_next    = 1'b1;
                                hid_next   = rd_ent.robot;
                                state_next = S_DONE;
                            end else if (pend_last_reg) begin
                                state_next = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_WRITE: begin
                // write the granted window, one slot per cycle
                mem_we          = 1'b1;
                mem_wdata.vld   = 1'b1;
                mem_wdata.robot = cmd_reg.robot_id;
                mem_wdata.stamp = tick_k_reg;
                tick_k_next     = tick_k_reg + 32'd1;
                slot_k_next     = slot_inc(slot_k_reg, tick_k_reg);
                cnt_next        = cnt_reg + SW'(1);
                if (cnt_reg == last_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = status_reg;
                    m_data_next.holder_valid = hv_reg;
                    m_data_next.holder_id    = hid_reg;
                    m_data_next.now_tick     = now_reg;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            now_reg      <= '0;
            now_slot_reg <= '0;
            rows_reg     <= GRID_RESET;
            cols_reg     <= GRID_RESET;
            issuing_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            now_reg      <= now_next;
            now_slot_reg <= now_slot_next;
            issuing_reg  <= issuing_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ROWS: rows_reg <= cfg_wdata;
                    CFG_COLS: cols_reg <= cfg_wdata;
                    default:  ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        base_reg      <= base_next;
        last_reg      <= last_next;
        cnt_reg       <= cnt_next;
        tick_k_reg    <= tick_k_next;
        slot_k_reg    <= slot_k_next;
        pend_last_reg <= pend_last_next;
        pend_tick_reg <= pend_tick_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        hv_reg        <= hv_next;
        hid_reg       <= hid_next;
        m_data_reg    <= m_data_next;
    end

    stcr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/stcr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module stcr_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
